>>> hw/rtl/upb_pkg.sv
// ----------------------------------------------------------------------------
// upb_pkg
// Shared types and constants for the uniform partition bounds block.
// ----------------------------------------------------------------------------
`default_nettype none

package upb_pkg;

    localparam int IDX_W = 64;            // index width of the mesh
    localparam int CW    = IDX_W - 1;     // child count width
    localparam int SW    = 7;             // shift amount width
    localparam int TW    = 20;            // tree index width
    localparam int WW    = 17;            // worker count width
    localparam int KW    = 16;            // worker rank width
    localparam int LW    = 5;             // refine level width
    localparam int RW    = WW + 2;        // divider remainder width
    localparam int CNTW  = $clog2(CW);    // divider bit counter width

    localparam int IN_DW  = 24;
    localparam int OUT_DW = 168;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_PYR  = 2'd1,
        ST_RANK = 2'd2,
        ST_OVF  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_DIM   = 2'd0,
        REG_TREES = 2'd1,
        REG_WORK  = 2'd2,
        REG_PYR   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        status_t         status;
        logic [SW-1:0]   shift;
        logic [CW-1:0]   total;
        logic [KW-1:0]   rank;
        logic            last_full;
    } job_t;

    typedef struct packed {
        logic [1:0]    c;
        logic [RW-1:0] r;
    } dstep_t;

    // one restoring step of floor(prefix*k/w): new remainder below w
    function automatic dstep_t div_step(input logic [RW-1:0] r, input logic b,
                                        input logic [WW-1:0] k,
                                        input logic [WW-1:0] w);
        logic [RW-1:0] t;
        logic [RW-1:0] w1;
        logic [RW-1:0] w2;
        dstep_t        res;
        t  = {r[RW-2:0], 1'b0} + (b ? {2'b00, k} : '0);
        w1 = {2'b00, w};
        w2 = {1'b0, w, 1'b0};
        if (t >= w2) begin
            res.c = 2'd2;
            res.r = t - w2;
        end else if (t >= w1) begin
            res.c = 2'd1;
            res.r = t - w1;
        end else begin
            res.c = 2'd0;
            res.r = t;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/uniform_partition_bounds.sv
// ----------------------------------------------------------------------------
// uniform_partition_bounds
// Share of one worker in a uniformly refined mesh: first/last tree and offsets.
// ----------------------------------------------------------------------------
//  channel   dir  ports        contents (lowest bit first)
//  s_axis    in   tdata[23:0]  refine_level[4:0], worker_rank[20:5]
//  m_axis    out  tdata[167:0] start_tree, begin_child, last_tree, end_child
//                 tuser[1:0]   status
//  cfg       in   we/index     0 dimension, 1 tree count, 2 workers, 3 pyramid
//
//  a request holds the back end from its pop off the queue through the
//  63 steps of the bit-serial share divider and the trees/offsets split in S_FIX1
//  and S_FIX2, where it waits until the output register is free to take its result
//  error requests skip the divider and S_FIX1 and get a zeroed result in S_FIX2
//  a two-entry queue keeps intake open while it has room and the divider or output stalls
//  reset is synchronous, active low; configuration takes effect at once
// ----------------------------------------------------------------------------
`default_nettype none

module uniform_partition_bounds (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        cfg_we,
    input  wire [1:0]                  cfg_index,
    input  wire [19:0]                 cfg_wdata,
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    // refine_level[4:0], worker_rank[20:5], zero pad
    input  wire [upb_pkg::IN_DW-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    // start_tree[19:0], begin_child[82:20], last_tree[102:83], end_child[165:103]
    output logic [upb_pkg::OUT_DW-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]                 m_axis_tuser
);
    import upb_pkg::*;

    logic          push_valid, push_ready, pop_valid, pop_ready;
    job_t          push_job, pop_job;
    logic [WW-1:0] workers;

    upb_front u_front (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .push_valid, .push_ready, .push_job, .workers
    );

    upb_queue u_queue (
        .aclk, .aresetn, .push_valid, .push_ready, .push_job,
        .pop_valid, .pop_ready, .pop_job
    );

    upb_back u_back (
        .aclk, .aresetn, .workers, .pop_valid, .pop_ready, .pop_job,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
    );

endmodule

`default_nettype wire

>>> hw/rtl/upb_front.sv
// ----------------------------------------------------------------------------
// upb_front
// Configuration registers, request intake and error classification.
// ----------------------------------------------------------------------------
`default_nettype none

module upb_front (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       cfg_we,
    input  wire [1:0]                 cfg_index,
    input  wire [19:0]                cfg_wdata,
    input  wire                       s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire [upb_pkg::IN_DW-1:0]  s_axis_tdata,
    output logic                      push_valid,
    input  wire                       push_ready,
    output upb_pkg::job_t             push_job,
    output logic [upb_pkg::WW-1:0]    workers
);
    import upb_pkg::*;

    logic [1:0]    dim_reg;
    logic [TW-1:0] trees_reg;
    logic [WW-1:0] work_reg;
    logic          pyr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg   <= 2'd2;
            trees_reg <= TW'(1);
            work_reg  <= WW'(1);
            pyr_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_DIM:   dim_reg   <= cfg_wdata[1:0];
                REG_TREES: trees_reg <= cfg_wdata[TW-1:0];
                REG_WORK:  work_reg  <= cfg_wdata[WW-1:0];
                REG_PYR:   pyr_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [LW-1:0]    level;
    logic [KW-1:0]    rank;
    logic [SW-1:0]    shift;
    logic [CW+TW-1:0] big;
    logic             ovf;

    assign level = s_axis_tdata[LW-1:0];
    assign rank  = s_axis_tdata[LW+KW-1:LW];
    assign shift = {5'b0, dim_reg} * {2'b0, level};
    assign big   = {{CW{1'b0}}, trees_reg} << shift;
    assign ovf   = (shift >= SW'(CW)) || (big[CW+TW-1:CW] != '0);

    always_comb begin
        push_job.shift     = shift;
        push_job.total     = big[CW-1:0];
        push_job.rank      = rank;
        push_job.last_full = ({1'b0, rank} + WW'(1)) == work_reg;
        if (pyr_reg)
            push_job.status = ST_PYR;
        else if ({1'b0, rank} >= work_reg)
            push_job.status = ST_RANK;
        else if (ovf)
            push_job.status = ST_OVF;
        else
            push_job.status = ST_OK;
    end

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;
    assign workers       = work_reg;

endmodule

`default_nettype wire

>>> hw/rtl/upb_queue.sv
// ----------------------------------------------------------------------------
// upb_queue
// Two-entry request queue between intake and the divider back end.
// ----------------------------------------------------------------------------
`default_nettype none

module upb_queue (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            push_valid,
    output logic           push_ready,
    input  upb_pkg::job_t  push_job,
    output logic           pop_valid,
    input  wire            pop_ready,
    output upb_pkg::job_t  pop_job
);
    import upb_pkg::*;

    job_t       mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign push_ready = cnt_reg != 2'd2;
    assign pop_valid  = cnt_reg != 2'd0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/upb_back.sv
// ----------------------------------------------------------------------------
// upb_back
// Bit-serial share divider, tree/offset split and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module upb_back (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire [upb_pkg::WW-1:0]      workers,
    input  wire                        pop_valid,
    output logic                       pop_ready,
    input  upb_pkg::job_t              pop_job,
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    output logic [upb_pkg::OUT_DW-1:0] m_axis_tdata,
    output logic [1:0]                 m_axis_tuser
);
    import upb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_FIX1 = 4'b0100,
        S_FIX2 = 4'b1000
    } state_t;

    state_t          state_reg;
    job_t            job_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [RW-1:0]   rem_a_reg, rem_b_reg;
    logic [CW-1:0]   qa_reg, qb_reg;
    logic [CW-1:0]   sel_reg, last_reg, begin_reg;
    logic [TW-1:0]   ftree_reg;

    logic            out_valid_reg;
    logic [TW-1:0]   o_ftree_reg, o_ltree_reg;
    logic [CW-1:0]   o_begin_reg, o_end_reg;
    status_t         o_status_reg;

    dstep_t          sa, sb;
    logic            bitv;
    logic [CW-1:0]   mask, first, last, sel;
    logic            out_free;

    assign bitv = job_reg.total[cnt_reg];
    assign sa   = div_step(rem_a_reg, bitv, {1'b0, job_reg.rank}, workers);
    assign sb   = div_step(rem_b_reg, bitv, {1'b0, job_reg.rank} + WW'(1), workers);

    assign mask  = ~({CW{1'b1}} << job_reg.shift);
    assign first = qa_reg;
    assign last  = job_reg.last_full ? job_reg.total : qb_reg;
    // empty share keeps last tree on first tree
    assign sel   = (first < last) ? last - CW'(1) : first;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign pop_ready = state_reg == S_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == S_FIX2 && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (pop_valid)
                        state_reg <= (pop_job.status == ST_OK) ? S_DIV : S_FIX2;
                end
                S_DIV: begin
                    if (cnt_reg == '0)
                        state_reg <= S_FIX1;
                end
                S_FIX1: state_reg <= S_FIX2;
                S_FIX2: begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                job_reg   <= pop_job;
                cnt_reg   <= CNTW'(CW - 1);
                rem_a_reg <= '0;
                rem_b_reg <= '0;
                qa_reg    <= '0;
                qb_reg    <= '0;
            end
            S_DIV: begin
                cnt_reg   <= cnt_reg - CNTW'(1);
                rem_a_reg <= sa.r;
                rem_b_reg <= sb.r;
                qa_reg    <= {qa_reg[CW-2:0], 1'b0} + {{(CW-2){1'b0}}, sa.c};
                qb_reg    <= {qb_reg[CW-2:0], 1'b0} + {{(CW-2){1'b0}}, sb.c};
            end
            S_FIX1: begin
                sel_reg   <= sel;
                last_reg  <= last;
                ftree_reg <= TW'(first >> job_reg.shift);
                begin_reg <= first & mask;
            end
            S_FIX2: begin
                if (out_free) begin
                    o_status_reg <= job_reg.status;
                    if (job_reg.status == ST_OK) begin
                        o_ftree_reg <= ftree_reg;
                        o_begin_reg <= begin_reg;
                        o_ltree_reg <= TW'(sel_reg >> job_reg.shift);
                        o_end_reg   <= last_reg - (sel_reg & ~mask);
                    end else begin
                        o_ftree_reg <= '0;
                        o_begin_reg <= '0;
                        o_ltree_reg <= '0;
                        o_end_reg   <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, o_end_reg, o_ltree_reg, o_begin_reg, o_ftree_reg};
    assign m_axis_tuser  = o_status_reg;

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> rem_a_reg < {2'b00, workers} && rem_b_reg < {2'b00, workers})
        else $error("divider remainder reached worker count");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && o_status_reg != ST_OK |->
            o_ftree_reg == '0 && o_ltree_reg == '0 && o_begin_reg == '0 && o_end_reg == '0)
        else $error("error result carries nonzero bounds");

    a_tree_order: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && o_status_reg == ST_OK |-> o_ltree_reg >= o_ftree_reg)
        else $error("last tree before first tree");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !pop_ready)
        else $error("queue popped while back end busy");

endmodule

`default_nettype wire
